@@ src/skt_pkg.sv @@
// Shared widths, codes and record types for the sorted key table.
package skt_pkg;

   localparam int KEY_W       = 16;
   localparam int NAME_W      = 4;
   localparam int POWER_W     = 10;
   localparam int LEVEL_W     = 7;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 5;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;
   localparam int MAX_RESULTS = 16;
   localparam int HIT_W       = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [POWER_W-1:0] power;
      logic [NAME_W-1:0]  name;
      logic [KEY_W-1:0]   key;
   } record_type;

   typedef struct packed {
      mode_type   mode;
      record_type rec;
   } op_type;

endpackage

@@ src/sorted_key_table.sv @@
// Top level of the sorted key table: front end, operation queue and table engine.
//
// The request channel (req_) carries one operation per beat: insert, remove or
// search, chosen by req_tuser. The response channel (rsp_) returns one beat
// for an insert, a remove or an unused code, and for a search one beat per
// matching record (at most sixteen) or a single not-found beat; rsp_tlast
// marks the final beat of each operation. rsp_tuser gives the status.
// Requests are registered by the front end and wait in a four-entry queue,
// so new beats are taken while the engine works or a response is stalled.
// The engine fetches an operation in its load state and executes it in the
// compare-and-shift cells in its execute state, writing the response register.
// A search emits its further hits at one beat per cycle while the receiver
// takes them. When the receiver stalls, the response register holds its beat
// and the engine waits; the queue then fills and req_tready falls. Reset
// empties the table and the queue.
module sorted_key_table import skt_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key [15:0], name_index [19:16], power [29:20], level [36:30], zero [39:37]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found_key [15:0], found_name [19:16], found_power [29:20],
   // found_level [36:30], occupancy [41:37], zero [47:42]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);

   logic             push_valid, push_ready, pop_valid, pop_ready;
   op_type           push_op, pop_op;
   status_type       rsp_status;
   record_type       rsp_rec;
   logic [OCC_W-1:0] rsp_occupancy;
   logic [CW-1:0]    count;

   skt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   skt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   skt_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (pop_valid),
      .op_ready      (pop_ready),
      .op            (pop_op),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_rec       (rsp_rec),
      .rsp_last      (rsp_tlast),
      .rsp_occupancy (rsp_occupancy),
      .count         (count)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {6'b0, rsp_occupancy, rsp_rec.level, rsp_rec.power,
                       rsp_rec.name, rsp_rec.key};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH))
      else $error("record count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count == $past(count) || count == CW'($past(count) + 1'b1) ||
                         count == CW'($past(count) - 1'b1)))
      else $error("record count moved by more than one");

   a_not_found_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_NOT_FOUND |-> rsp_tlast && rsp_tdata[36:0] == '0)
      else $error("not-found beat carries a record or is not final");

   a_full_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> rsp_tlast && count == CW'(DEPTH))
      else $error("table-full status while the table has room");

endmodule

@@ src/skt_front.sv @@
// Request front end: accepts request beats, decodes them and hands them to the queue.
module skt_front import skt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output op_type                push_op
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept;

   assign req_tready = !valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_op    = op_ff;

   always_comb begin
      valid_in = accept || (valid_ff && !push_ready);
      op_in    = op_ff;
      if (accept) begin
         op_in.mode    = mode_type'(req_tuser);
         op_in.rec.key = req_tdata[KEY_W-1:0];
         // Only an insert carries a payload; other operations keep it cleared.
         if (mode_type'(req_tuser) == MODE_INSERT) begin
            op_in.rec.name  = req_tdata[19:16];
            op_in.rec.power = req_tdata[29:20];
            op_in.rec.level = req_tdata[36:30];
         end else begin
            op_in.rec.name  = '0;
            op_in.rec.power = '0;
            op_in.rec.level = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

endmodule

@@ src/skt_queue.sv @@
// Short operation queue between the front end and the table engine.
module skt_queue import skt_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [QUEUE_AW:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = fill_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_op     = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in = do_push ? QUEUE_AW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = do_pop ? QUEUE_AW'(rptr_ff + 1'b1) : rptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = (QUEUE_AW+1)'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = (QUEUE_AW+1)'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_op;
      end
   end

endmodule

@@ src/skt_back.sv @@
// Table engine: compare-and-shift record cells, operation sequencer and response register.
module skt_back import skt_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_ready,
   input  op_type           op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output status_type       rsp_status,
   output record_type       rsp_rec,
   output logic             rsp_last,
   output logic [OCC_W-1:0] rsp_occupancy,
   output logic [CW-1:0]    count
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_EXEC,
      ST_SEARCH
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [DEPTH-1:0] sel_ff, sel_in;
   logic [HIT_W-1:0] hits_ff, hits_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   record_type       rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   record_type       cells_ff [DEPTH];
   record_type       cells_in [DEPTH];

   logic [DEPTH-1:0] lt, eq, start, first_hit, pick, next_mask;
   logic             found, out_free, last_hit;
   record_type       pick_rec;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_rec       = rsp_rec_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign count         = count_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CW'(i) < count_ff) && (cells_ff[i].key < op_ff.rec.key);
         eq[i] = (CW'(i) < count_ff) && (cells_ff[i].key == op_ff.rec.key);
      end
      // The table is sorted, so the cells below the key form a prefix and
      // the matching cells form one run that starts where that prefix ends.
      start[0] = !lt[0];
      for (int i = 1; i < DEPTH; i++) begin
         start[i] = !lt[i] && lt[i-1];
      end
      first_hit = start & eq;
      found     = |eq;
      out_free  = !rsp_valid_ff || rsp_ready;
      pick      = (state_ff == ST_EXEC) ? first_hit : sel_ff;
      next_mask = (pick << 1) & eq;
      pick_rec  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pick[i]) begin
            pick_rec = record_type'(pick_rec | cells_ff[i]);
         end
      end

      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      sel_in        = sel_ff;
      hits_in       = hits_ff;
      cells_in      = cells_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;
      op_ready      = 1'b0;
      last_hit      = 1'b1;

      unique case (state_ff)
         ST_LOAD: begin
            op_ready = 1'b1;
            if (op_valid) begin
               op_in    = op;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_rec_in    = '0;
               rsp_status_in = STATUS_OK;
               state_in      = ST_LOAD;
               unique case (op_ff.mode)
                  MODE_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           if (start[i]) begin
                              cells_in[i] = op_ff.rec;
                           end
                        end
                        for (int i = 1; i < DEPTH; i++) begin
                           if (!lt[i] && !start[i]) begin
                              cells_in[i] = cells_ff[i-1];
                           end
                        end
                        count_in = CW'(count_ff + 1'b1);
                     end
                  end
                  MODE_REMOVE: begin
                     if (found) begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                           if (!lt[i]) begin
                              cells_in[i] = cells_ff[i+1];
                           end
                        end
                        count_in = CW'(count_ff - 1'b1);
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  MODE_SEARCH: begin
                     if (found) begin
                        rsp_rec_in  = pick_rec;
                        hits_in     = HIT_W'(1);
                        last_hit    = (next_mask == '0) || (hits_in == HIT_W'(MAX_RESULTS));
                        rsp_last_in = last_hit;
                        if (!last_hit) begin
                           sel_in   = next_mask;
                           state_in = ST_SEARCH;
                        end
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_occ_in = OCC_W'(count_in);
            end
         end
         ST_SEARCH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_rec_in    = pick_rec;
               rsp_occ_in    = OCC_W'(count_ff);
               hits_in       = HIT_W'(hits_ff + 1'b1);
               last_hit      = (next_mask == '0) || (hits_in == HIT_W'(MAX_RESULTS));
               rsp_last_in   = last_hit;
               sel_in        = next_mask;
               if (last_hit) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      hits_ff       <= hits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
   end

endmodule
